// ----- rtl/e2h_pkg.sv -----
// ----------------------------------------------------------------------------
// e2h_pkg
// Shared constants for the Euler-angle to homogeneous transform pipeline:
// default widths, Q30 angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2h_pkg;

  // default field widths
  localparam int ANGLE_WIDTH     = 16;
  localparam int SHIFT_WIDTH     = 32;
  localparam int COEFF_FRAC_BITS = 14;

  // CORDIC depth, one iteration per pipeline stage
  localparam int CORDIC_ITERS = 30;

  // angle constants in Q30
  localparam longint Q30_PI      = 64'sd3373259426;
  localparam longint Q30_TWO_PI  = 64'sd6746518852;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam longint Q30_GAIN    = 64'sd652032874;

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      24: v = 32'd64;
      25: v = 32'd32;
      26: v = 32'd16;
      27: v = 32'd8;
      28: v = 32'd4;
      29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/euler_to_homogeneous_transform.sv -----
// ----------------------------------------------------------------------------
// euler_to_homogeneous_transform
// Turns three Euler angles (R = Rx*Ry*Rz) and a translation into the top
// three rows of a 4x4 homogeneous transform, fully pipelined.
//
//  channel  | dir | tdata fields (low bit first)
//  s_axis   | in  | angle_x, angle_y, angle_z, shift_x, shift_y, shift_z
//  m_axis   | out | r00..r22 (Q1.F), t0, t1, t2
//
// There are CORDIC_ITERS + 7 register stages (37 by default). One beat is
// taken every cycle while the pipeline is not stalled. Depth is set by the
// 30-stage CORDIC, one iteration a stage.
// Reset clears the valid bits only; data registers are not reset.
// All stages advance together whenever the output register is empty or
// being taken, so a stall holds every beat in place.
// ----------------------------------------------------------------------------
module euler_to_homogeneous_transform #(
  parameter int ANGLE_WIDTH     = e2h_pkg::ANGLE_WIDTH,
  parameter int SHIFT_WIDTH     = e2h_pkg::SHIFT_WIDTH,
  parameter int COEFF_FRAC_BITS = e2h_pkg::COEFF_FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // angle_x, angle_y, angle_z, shift_x, shift_y, shift_z, zero pad
  input  logic [((3*ANGLE_WIDTH+3*SHIFT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, t0, t1, t2, zero pad
  output logic [((9*(COEFF_FRAC_BITS+2)+3*SHIFT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

  localparam int ITERS = e2h_pkg::CORDIC_ITERS;
  localparam int AS    = 30 - (ANGLE_WIDTH - 4);
  localparam int F     = COEFF_FRAC_BITS;
  localparam int CW    = F + 2;
  localparam int RW    = 36;
  localparam int XW    = 34;
  localparam int NST   = ITERS + 7;

  localparam logic signed [RW-1:0] PI_Q      = RW'(e2h_pkg::Q30_PI);
  localparam logic signed [RW-1:0] TWO_PI_Q  = RW'(e2h_pkg::Q30_TWO_PI);
  localparam logic signed [RW-1:0] HALF_PI_Q = RW'(e2h_pkg::Q30_HALF_PI);
  localparam logic signed [XW-1:0] GAIN_Q    = XW'(e2h_pkg::Q30_GAIN);
  localparam logic signed [CW+1:0] ONE_S     = (CW+2)'(1) <<< F;
  localparam logic signed [XW-1:0] CO_RND    = XW'(1) <<< (29 - F);
  localparam logic signed [2*CW-1:0] MU_RND  = (2*CW)'(1) <<< (F - 1);

  // saturate to plus or minus one
  function automatic logic signed [CW-1:0] sat_one(input logic signed [CW+1:0] v);
    logic signed [CW+1:0] r;
    if (v > ONE_S)       r = ONE_S;
    else if (v < -ONE_S) r = -ONE_S;
    else                 r = v;
    return r[CW-1:0];
  endfunction

  // product rounded half up to Q1.F
  function automatic logic signed [CW+1:0] mul_rnd(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
    logic signed [2*CW-1:0] p;
    p = (a * b) + MU_RND;
    p = p >>> F;
    return p[CW+1:0];
  endfunction

  // Q30 to Q1.F with rounding and saturation
  function automatic logic signed [CW-1:0] to_coeff(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] s;
    s = (v + CO_RND) >>> (30 - F);
    if (s > XW'(ONE_S))       s = XW'(ONE_S);
    else if (s < -XW'(ONE_S)) s = -XW'(ONE_S);
    return s[CW-1:0];
  endfunction

  logic en;
  logic [NST-1:0] v_q;

  logic [SHIFT_WIDTH-1:0] t_q [NST][3];

  logic signed [RW-1:0] a0_q [3];
  logic signed [RW-1:0] a1_q [3];
  logic signed [XW-1:0] x_q [ITERS+1][3];
  logic signed [XW-1:0] y_q [ITERS+1][3];
  logic signed [XW-1:0] z_q [ITERS+1][3];
  logic                 ng_q [ITERS+1][3];
  logic signed [CW-1:0] s_q [3];
  logic signed [CW-1:0] c_q [3];
  logic signed [CW-1:0] s1_q [3];
  logic signed [CW-1:0] c1_q [3];
  logic signed [CW-1:0] sxsy_q, cxsy_q;
  logic signed [CW+1:0] m_q [13];
  logic signed [CW-1:0] r_q [9];

  // whole pipeline moves together
  assign en            = !v_q[NST-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v_q[NST-1];

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], s_axis_tvalid};
    end
  end

  // translation shift line
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        t_q[0][k] <= s_axis_tdata[3*ANGLE_WIDTH + k*SHIFT_WIDTH +: SHIFT_WIDTH];
        for (int n = 1; n < NST; n++) t_q[n][k] <= t_q[n-1][k];
      end
    end
  end

  // capture, scale to Q30, reduce by 2*pi, fold into +-pi/2
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a0_q[k] <= $signed({{(RW-ANGLE_WIDTH){s_axis_tdata[k*ANGLE_WIDTH+ANGLE_WIDTH-1]}},
                            s_axis_tdata[k*ANGLE_WIDTH +: ANGLE_WIDTH]}) <<< AS;
        if (a0_q[k] > PI_Q)       a1_q[k] <= a0_q[k] - TWO_PI_Q;
        else if (a0_q[k] < -PI_Q) a1_q[k] <= a0_q[k] + TWO_PI_Q;
        else                      a1_q[k] <= a0_q[k];
        x_q[0][k] <= GAIN_Q;
        y_q[0][k] <= '0;
        if (a1_q[k] > HALF_PI_Q) begin
          z_q[0][k]  <= XW'(PI_Q - a1_q[k]);
          ng_q[0][k] <= 1'b1;
        end else if (a1_q[k] < -HALF_PI_Q) begin
          z_q[0][k]  <= XW'(-PI_Q - a1_q[k]);
          ng_q[0][k] <= 1'b1;
        end else begin
          z_q[0][k]  <= XW'(a1_q[k]);
          ng_q[0][k] <= 1'b0;
        end
      end
    end
  end

  // CORDIC rotation, one iteration per stage
  for (genvar i = 0; i < ITERS; i++) begin : g_cordic
    localparam logic signed [XW-1:0] ATAN_Q = $signed({{(XW-32){1'b0}}, e2h_pkg::atan_q30(i)});
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          ng_q[i+1][k] <= ng_q[i][k];
          if (!z_q[i][k][XW-1]) begin
            x_q[i+1][k] <= x_q[i][k] - (y_q[i][k] >>> i);
            y_q[i+1][k] <= y_q[i][k] + (x_q[i][k] >>> i);
            z_q[i+1][k] <= z_q[i][k] - ATAN_Q;
          end else begin
            x_q[i+1][k] <= x_q[i][k] + (y_q[i][k] >>> i);
            y_q[i+1][k] <= y_q[i][k] - (x_q[i][k] >>> i);
            z_q[i+1][k] <= z_q[i][k] + ATAN_Q;
          end
        end
      end
    end
  end

  // sine/cosine to Q1.F, then the two shared products, then all products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s_q[k] <= to_coeff(y_q[ITERS][k]);
        c_q[k] <= to_coeff(ng_q[ITERS][k] ? -x_q[ITERS][k] : x_q[ITERS][k]);
        s1_q[k] <= s_q[k];
        c1_q[k] <= c_q[k];
      end
      sxsy_q <= sat_one(mul_rnd(s_q[0], s_q[1]));
      cxsy_q <= sat_one(mul_rnd(c_q[0], s_q[1]));
      m_q[0]  <= mul_rnd(c1_q[1], c1_q[2]);
      m_q[1]  <= -mul_rnd(c1_q[1], s1_q[2]);
      m_q[2]  <= (CW+2)'(s1_q[1]);
      m_q[3]  <= mul_rnd(sxsy_q, c1_q[2]);
      m_q[4]  <= mul_rnd(c1_q[0], s1_q[2]);
      m_q[5]  <= -mul_rnd(sxsy_q, s1_q[2]);
      m_q[6]  <= mul_rnd(c1_q[0], c1_q[2]);
      m_q[7]  <= -mul_rnd(s1_q[0], c1_q[1]);
      m_q[8]  <= -mul_rnd(cxsy_q, c1_q[2]);
      m_q[9]  <= mul_rnd(s1_q[0], s1_q[2]);
      m_q[10] <= mul_rnd(cxsy_q, s1_q[2]);
      m_q[11] <= mul_rnd(s1_q[0], c1_q[2]);
      m_q[12] <= mul_rnd(c1_q[0], c1_q[1]);
    end
  end

  // entry sums and saturation into the output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0] <= sat_one(m_q[0]);
      r_q[1] <= sat_one(m_q[1]);
      r_q[2] <= sat_one(m_q[2]);
      r_q[3] <= sat_one(m_q[3] + m_q[4]);
      r_q[4] <= sat_one(m_q[5] + m_q[6]);
      r_q[5] <= sat_one(m_q[7]);
      r_q[6] <= sat_one(m_q[8] + m_q[9]);
      r_q[7] <= sat_one(m_q[10] + m_q[11]);
      r_q[8] <= sat_one(m_q[12]);
    end
  end

  // output packing
  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 9; k++) m_axis_tdata[k*CW +: CW] = r_q[k];
    for (int k = 0; k < 3; k++) m_axis_tdata[9*CW + k*SHIFT_WIDTH +: SHIFT_WIDTH] = t_q[NST-1][k];
  end

`ifndef SYNTHESIS
  a_red_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (a1_q[0] <= PI_Q && a1_q[0] >= -PI_Q))
    else $error("reduced angle out of range");
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> (z_q[0][1] <= XW'(HALF_PI_Q) && z_q[0][1] >= -XW'(HALF_PI_Q)))
    else $error("folded angle out of range");
  a_coeff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (r_q[4] <= CW'(ONE_S) && r_q[4] >= -CW'(ONE_S)))
    else $error("rotation entry beyond one");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during stall");
`endif

endmodule
